// File: src/bts_pkg.sv
`default_nettype none
package bts_pkg;

  localparam int SIZE_DEF = 64;

  localparam logic [31:0] PAD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PAD_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_LOAD   = 4'd0,
    S_SETUP  = 4'd1,
    S_PAD    = 4'd2,
    S_CHECK  = 4'd3,
    S_READ   = 4'd4,
    S_WRP    = 4'd5,
    S_WRQ    = 4'd6,
    S_EMIT   = 4'd7,
    S_ERD    = 4'd8,
    S_EPUSH  = 4'd9,
    S_ENEXT  = 4'd10,
    S_DONE   = 4'd11
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP,
    OP_PAD,
    OP_RD_PAIR,
    OP_WR_P,
    OP_WR_Q,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_PUSH,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_ACC_LAST,
    C_PAD_LEFT,
    C_SPAN_ONE,
    C_NOT_DONE,
    C_OUT_BUSY,
    C_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic acc_last;
    logic pad_left;
    logic span_one;
    logic sort_done;
    logic out_busy;
    logic emit_more;
  } flags_t;

  // microcode program: taken branch goes to target, otherwise to the next step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{op: OP_FINISH, cond: C_ALWAYS, target: S_LOAD};
    unique case (s)
      S_LOAD:  w = '{op: OP_LOAD,      cond: C_NOT_ACC_LAST, target: S_LOAD};
      S_SETUP: w = '{op: OP_SETUP,     cond: C_NONE,         target: S_LOAD};
      S_PAD:   w = '{op: OP_PAD,       cond: C_PAD_LEFT,     target: S_PAD};
      S_CHECK: w = '{op: OP_NOP,       cond: C_SPAN_ONE,     target: S_EMIT};
      S_READ:  w = '{op: OP_RD_PAIR,   cond: C_NONE,         target: S_LOAD};
      S_WRP:   w = '{op: OP_WR_P,      cond: C_NONE,         target: S_LOAD};
      S_WRQ:   w = '{op: OP_WR_Q,      cond: C_NOT_DONE,     target: S_READ};
      S_EMIT:  w = '{op: OP_EMIT_INIT, cond: C_NONE,         target: S_LOAD};
      S_ERD:   w = '{op: OP_EMIT_RD,   cond: C_NONE,         target: S_LOAD};
      S_EPUSH: w = '{op: OP_EMIT_PUSH, cond: C_OUT_BUSY,     target: S_EPUSH};
      S_ENEXT: w = '{op: OP_NOP,       cond: C_EMIT_MORE,    target: S_ERD};
      S_DONE:  w = '{op: OP_FINISH,    cond: C_ALWAYS,       target: S_LOAD};
      default: w = '{op: OP_FINISH,    cond: C_ALWAYS,       target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/bts_seq.sv
`default_nettype none
module bts_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bts_pkg::flags_t flags,
  output bts_pkg::op_t         op
);
  import bts_pkg::*;

  step_t pc;
  step_t pc_next;
  ctrl_t word;
  logic  taken;

  assign word = ucode(pc);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      C_NONE:         taken = 1'b0;
      C_ALWAYS:       taken = 1'b1;
      C_NOT_ACC_LAST: taken = !flags.acc_last;
      C_PAD_LEFT:     taken = flags.pad_left;
      C_SPAN_ONE:     taken = flags.span_one;
      C_NOT_DONE:     taken = !flags.sort_done;
      C_OUT_BUSY:     taken = flags.out_busy;
      C_EMIT_MORE:    taken = flags.emit_more;
      default:        taken = 1'b0;
    endcase
    if (taken) begin
      pc_next = word.target;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// File: src/bitonic_sorter.sv
// loading: one word per cycle, the word marked last included.
// sort: setup, padding entries written one by one, then per compare-exchange a pair read,
//   a write of p and a write of q; (span/2)*log2(span)*(log2(span)+1)/2 of them, 672 for a full store of 64.
// output: each word is read, then pushed once out_stall lets it go; no new load until the last push.
// reset clears the sequencer, the count and the output valid, and sets sort_ascending to 1;
// the element store is not cleared.
`default_nettype none
module bitonic_sorter #(
  parameter int SIZE = bts_pkg::SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] value,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      value_res,
  output logic                    last_res
);
  import bts_pkg::*;

  localparam int NAW       = $clog2(SIZE);
  localparam int NET_DEPTH = 1 << NAW;
  localparam int SW        = NAW + 1;
  localparam int CW        = $clog2(SIZE + 1);

  function automatic logic [SW-1:0] ceil_pow2(input logic [CW-1:0] n);
    logic [SW-1:0] r;
    r = SW'(1);
    for (int b = 0; b < NAW; b++) begin
      if ((SW'(1) << b) < SW'(n)) begin
        r = SW'(1) << (b + 1);
      end
    end
    return r;
  endfunction

  op_t    op;
  flags_t flags;

  logic          sort_ascending;
  logic [CW-1:0] count;
  logic [SW-1:0] span;
  logic [SW-1:0] pad_idx;
  logic [SW-1:0] kk;
  logic [SW-1:0] jj;
  logic [NAW-1:0] c;
  logic [CW-1:0] out_idx;

  logic [31:0] mem [NET_DEPTH];
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] q_hold;

  logic [NAW-1:0] mask;
  logic [NAW-1:0] p_idx;
  logic [NAW-1:0] q_idx;
  logic [NAW-1:0] addr_a;
  logic           c_last;
  logic           jj_one;
  logic           kk_full;
  logic           dir_up;
  logic           swap;
  logic           push;
  logic           load_acc;

  bts_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  assign in_stall = (op != OP_LOAD);
  assign load_acc = in_valid && (op == OP_LOAD);

  // pair index: insert a zero bit at the distance bit position
  assign mask    = NAW'(jj - SW'(1));
  assign p_idx   = ((c & ~mask) << 1) | (c & mask);
  assign q_idx   = p_idx | NAW'(jj);
  assign c_last  = (SW'(c) + SW'(1)) == (span >> 1);
  assign jj_one  = (jj == SW'(1));
  assign kk_full = (kk == span);
  assign dir_up  = kk_full ? sort_ascending : ((SW'(p_idx) & kk) == '0);
  assign swap    = (($signed(rd_a) > $signed(rd_b)) == dir_up);
  assign push    = (op == OP_EMIT_PUSH) && !flags.out_busy;

  assign addr_a = (op == OP_EMIT_RD || op == OP_EMIT_PUSH) ? out_idx[NAW-1:0] : p_idx;

  assign flags.acc_last  = in_valid && last;
  assign flags.pad_left  = pad_idx < span;
  assign flags.span_one  = (span == SW'(1));
  assign flags.sort_done = c_last && jj_one && kk_full;
  assign flags.out_busy  = out_valid && out_stall;
  assign flags.emit_more = out_idx < count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_ascending <= 1'b1;
    end else if (cfg_wr_en) begin
      sort_ascending <= cfg_wr_data;
    end
  end

  // element store: two registered read ports, one write port
  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
    rd_b <= mem[q_idx];
    case (op)
      OP_LOAD: begin
        if (load_acc && count < CW'(SIZE)) begin
          mem[count[NAW-1:0]] <= value;
        end
      end
      OP_PAD: begin
        if (flags.pad_left) begin
          mem[pad_idx[NAW-1:0]] <= sort_ascending ? PAD_MAX : PAD_MIN;
        end
      end
      OP_WR_P: begin
        mem[p_idx] <= swap ? rd_b : rd_a;
      end
      OP_WR_Q: begin
        mem[q_idx] <= q_hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == OP_WR_P) begin
      q_hold <= swap ? rd_a : rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_acc && count < CW'(SIZE)) begin
      count <= count + CW'(1);
    end else if (op == OP_FINISH) begin
      count <= '0;
    end
  end

  // network counters: stage size kk, distance jj, pair c; also span, pad index and output index
  always_ff @(posedge clk) begin
    unique case (op)
      OP_SETUP: begin
        span    <= ceil_pow2(count);
        pad_idx <= SW'(count);
        kk      <= SW'(2);
        jj      <= SW'(1);
        c       <= '0;
      end
      OP_PAD: begin
        if (flags.pad_left) begin
          pad_idx <= pad_idx + SW'(1);
        end
      end
      OP_WR_Q: begin
        if (!c_last) begin
          c <= c + NAW'(1);
        end else begin
          c <= '0;
          if (!jj_one) begin
            jj <= jj >> 1;
          end else if (!kk_full) begin
            kk <= kk << 1;
            jj <= kk;
          end
        end
      end
      OP_EMIT_INIT: begin
        out_idx <= '0;
      end
      OP_EMIT_PUSH: begin
        if (push) begin
          out_idx <= out_idx + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      value_res <= rd_a;
      last_res  <= (out_idx + CW'(1)) == count;
    end
  end

endmodule
`default_nettype wire
